// ===== src/fckvt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package fckvt_pkg;

  // Operation codes carried in a request.
  localparam logic [2:0] OP_INSERT = 3'd0;
  localparam logic [2:0] OP_UPDATE = 3'd1;
  localparam logic [2:0] OP_UPSERT = 3'd2;
  localparam logic [2:0] OP_ERASE  = 3'd3;
  localparam logic [2:0] OP_LOOKUP = 3'd4;
  localparam logic [2:0] OP_READ   = 3'd5;

  typedef struct packed {
    logic [2:0]  operation;
    logic [31:0] key_in;
    logic [31:0] value_in;
    logic [3:0]  slot_index;
  } req_t;

  typedef struct packed {
    logic        success;
    logic [31:0] key_out;
    logic [31:0] value_out;
    logic [4:0]  entry_count;
  } rsp_t;

endpackage

`default_nettype wire

// ===== src/fckvt_store.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Key and value arrays with one write port and one registered read port.
module fckvt_store #(
  parameter int DEPTH = 16,
  parameter int AW    = 4,
  parameter int KW    = 32,
  parameter int VW    = 32
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [KW-1:0] wr_key,
  input  wire logic [VW-1:0] wr_value,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [KW-1:0] rd_key,
  output logic      [VW-1:0] rd_value
);

  logic [KW-1:0] key_mem   [DEPTH];
  logic [VW-1:0] value_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem[wr_addr]   <= wr_key;
      value_mem[wr_addr] <= wr_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_key   <= key_mem[rd_addr];
      rd_value <= value_mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== src/fckvt_seq.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Sequencer: walks the table one slot per cycle through the single read port,
// compares each stored key with the request key and writes back where the operation needs it.
module fckvt_seq #(
  parameter int CAPACITY = 16,
  parameter int KW       = 32,
  parameter int VW       = 32,
  parameter int AW       = 4,
  parameter int CW       = 5
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire fckvt_pkg::req_t  req,
  output logic                  idle,
  output logic                  done,
  input  wire logic             out_free,
  output fckvt_pkg::rsp_t       result,
  output logic                  wr_en,
  output logic         [AW-1:0] wr_addr,
  output logic         [KW-1:0] wr_key,
  output logic         [VW-1:0] wr_value,
  output logic                  rd_en,
  output logic         [AW-1:0] rd_addr,
  input  wire logic    [KW-1:0] rd_key,
  input  wire logic    [VW-1:0] rd_value
);

  localparam int IW  = (CW > 4) ? CW : 4;
  localparam int CW5 = (CW > 5) ? CW : 5;

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_SEARCH   = 3'd1;
  localparam logic [2:0] ST_ERASE_RD = 3'd2;
  localparam logic [2:0] ST_ERASE_WR = 3'd3;
  localparam logic [2:0] ST_IDX_RD   = 3'd4;
  localparam logic [2:0] ST_IDX_CAP  = 3'd5;
  localparam logic [2:0] ST_FINISH   = 3'd6;

  logic [2:0]    state, state_next;
  logic [CW-1:0] count, count_next;
  logic [2:0]    op, op_next;
  logic [KW-1:0] key_q, key_q_next;
  logic [VW-1:0] value_q, value_q_next;
  logic [3:0]    idx, idx_next;
  logic [CW-1:0] scan_addr, scan_addr_next;
  logic          pend, pend_next;
  logic [AW-1:0] pend_addr, pend_addr_next;
  logic [AW-1:0] hit_slot, hit_slot_next;
  logic          ok, ok_next;
  logic [31:0]   kout, kout_next;
  logic [31:0]   vout, vout_next;

  logic          issue;
  logic          hit;
  logic          has_room;
  logic [IW-1:0] idx_ext;
  logic [CW5-1:0] count_ext;

  assign issue     = scan_addr < count;
  assign hit       = pend && (rd_key == key_q);
  assign has_room  = count < CW'(CAPACITY);
  assign idx_ext   = IW'(idx);
  assign count_ext = CW5'(count);

  assign idle = (state == ST_IDLE);

  always_comb begin
    result.success     = ok;
    result.key_out     = kout;
    result.value_out   = vout;
    result.entry_count = count_ext[4:0];
  end

  always_comb begin
    state_next     = state;
    count_next     = count;
    op_next        = op;
    key_q_next     = key_q;
    value_q_next   = value_q;
    idx_next       = idx;
    scan_addr_next = scan_addr;
    pend_next      = pend;
    pend_addr_next = pend_addr;
    hit_slot_next  = hit_slot;
    ok_next        = ok;
    kout_next      = kout;
    vout_next      = vout;
    wr_en          = 1'b0;
    wr_addr        = pend_addr;
    wr_key         = key_q;
    wr_value       = value_q;
    rd_en          = 1'b0;
    rd_addr        = scan_addr[AW-1:0];
    done           = 1'b0;

    unique case (state)
      ST_IDLE: begin
        if (start) begin
          op_next        = req.operation;
          key_q_next     = KW'(req.key_in);
          value_q_next   = VW'(req.value_in);
          idx_next       = req.slot_index;
          scan_addr_next = '0;
          pend_next      = 1'b0;
          ok_next        = 1'b0;
          kout_next      = '0;
          vout_next      = '0;
          unique case (req.operation) inside
            fckvt_pkg::OP_INSERT, fckvt_pkg::OP_UPDATE, fckvt_pkg::OP_UPSERT,
            fckvt_pkg::OP_ERASE, fckvt_pkg::OP_LOOKUP: state_next = ST_SEARCH;
            fckvt_pkg::OP_READ:                         state_next = ST_IDX_RD;
            default:                                    state_next = ST_FINISH;
          endcase
        end
      end

      ST_SEARCH: begin
        // Read slot scan_addr while comparing the slot read in the previous cycle.
        rd_en          = issue;
        pend_next      = issue;
        pend_addr_next = scan_addr[AW-1:0];
        if (issue) begin
          scan_addr_next = scan_addr + CW'(1);
        end
        if (hit) begin
          hit_slot_next = pend_addr;
          state_next    = ST_FINISH;
          case (op) inside
            fckvt_pkg::OP_UPDATE, fckvt_pkg::OP_UPSERT: begin
              wr_en   = 1'b1;
              wr_addr = pend_addr;
              ok_next = 1'b1;
            end
            fckvt_pkg::OP_ERASE: begin
              state_next = ST_ERASE_RD;
            end
            fckvt_pkg::OP_LOOKUP: begin
              vout_next = 32'(rd_value);
              ok_next   = 1'b1;
            end
            default: begin
              ok_next = 1'b0;
            end
          endcase
        end else if (!pend && !issue) begin
          // The whole table has been compared without a match.
          state_next = ST_FINISH;
          if ((op == fckvt_pkg::OP_INSERT || op == fckvt_pkg::OP_UPSERT) && has_room) begin
            wr_en      = 1'b1;
            wr_addr    = count[AW-1:0];
            count_next = count + CW'(1);
            ok_next    = 1'b1;
          end
        end
      end

      ST_ERASE_RD: begin
        rd_en      = 1'b1;
        rd_addr    = AW'(count - CW'(1));
        state_next = ST_ERASE_WR;
      end

      ST_ERASE_WR: begin
        // Move the last pair into the freed slot.
        wr_en      = 1'b1;
        wr_addr    = hit_slot;
        wr_key     = rd_key;
        wr_value   = rd_value;
        count_next = count - CW'(1);
        ok_next    = 1'b1;
        state_next = ST_FINISH;
      end

      ST_IDX_RD: begin
        rd_addr = idx_ext[AW-1:0];
        if (idx_ext < IW'(count)) begin
          rd_en      = 1'b1;
          state_next = ST_IDX_CAP;
        end else begin
          state_next = ST_FINISH;
        end
      end

      ST_IDX_CAP: begin
        kout_next  = 32'(rd_key);
        vout_next  = 32'(rd_value);
        ok_next    = 1'b1;
        state_next = ST_FINISH;
      end

      ST_FINISH: begin
        done = 1'b1;
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      pend  <= pend_next;
    end
  end

  always_ff @(posedge clk) begin
    op        <= op_next;
    key_q     <= key_q_next;
    value_q   <= value_q_next;
    idx       <= idx_next;
    scan_addr <= scan_addr_next;
    pend_addr <= pend_addr_next;
    hit_slot  <= hit_slot_next;
    ok        <= ok_next;
    kout      <= kout_next;
    vout      <= vout_next;
  end

  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("pair count exceeds capacity");

  a_count_source : assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && count != $past(count)) |->
      ($past(state) == ST_SEARCH || $past(state) == ST_ERASE_WR))
    else $error("pair count changed outside a write-back state");

  a_write_state : assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (state == ST_SEARCH || state == ST_ERASE_WR))
    else $error("table written outside a write-back state");

  a_finish_release : assert property (@(posedge clk) disable iff (rst)
    (done && out_free) |=> (state == ST_IDLE))
    else $error("sequencer did not return to idle after handing over a result");

endmodule

`default_nettype wire

// ===== src/fixed_capacity_key_value_table_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Fixed-capacity key/value table. Up to CAPACITY pairs are held densely in
// slots 0 to count-1 of a memory with one write and one read port, and the
// requests insert, update, insert-or-update, erase (the last pair is moved
// into the freed slot) and lookup are served by a linear search, while
// read-by-index reads its slot directly. Each request answers with one
// response that also carries the entry count after the operation. The
// block works on one request at a time. The search reads one slot per cycle
// through the memory's only read port: a request is started, the table is
// scanned with the registered read and the result is handed over; an erase
// that hits also fetches and writes back the last pair, and read-by-index
// reads its slot only when the slot is held. The memory is not cleared at
// reset; only slots below the entry count are ever read. A finished response
// waits in an output register, so a new request may be taken while the
// previous response is still stalled.
module fixed_capacity_key_value_table_top #(
  parameter int CAPACITY   = 16,
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             req_valid,
  output logic                  req_stall,
  input  wire fckvt_pkg::req_t  req_data,
  output logic                  rsp_valid,
  input  wire logic             rsp_stall,
  output fckvt_pkg::rsp_t       rsp_data
);

  // Address width for the slots, and count width able to hold CAPACITY itself.
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  logic                  idle;
  logic                  start;
  logic                  done;
  logic                  out_free;
  fckvt_pkg::rsp_t       result;
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [KEY_BITS-1:0]   wr_key;
  logic [VALUE_BITS-1:0] wr_value;
  logic                  rd_en;
  logic [AW-1:0]         rd_addr;
  logic [KEY_BITS-1:0]   rd_key;
  logic [VALUE_BITS-1:0] rd_value;

  // A request is taken only while the sequencer is idle.
  assign req_stall = !idle;
  assign start     = req_valid && idle;

  // The output register can take a new response when it is empty or its
  // current response leaves at this edge.
  assign out_free = !rsp_valid || !rsp_stall;

  fckvt_seq #(
    .CAPACITY (CAPACITY),
    .KW       (KEY_BITS),
    .VW       (VALUE_BITS),
    .AW       (AW),
    .CW       (CW)
  ) u_seq (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .req      (req_data),
    .idle     (idle),
    .done     (done),
    .out_free (out_free),
    .result   (result),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_key   (wr_key),
    .wr_value (wr_value),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_key   (rd_key),
    .rd_value (rd_value)
  );

  fckvt_store #(
    .DEPTH (CAPACITY),
    .AW    (AW),
    .KW    (KEY_BITS),
    .VW    (VALUE_BITS)
  ) u_store (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_key   (wr_key),
    .wr_value (wr_value),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_key   (rd_key),
    .rd_value (rd_value)
  );

  // Response register: loaded when the sequencer finishes and there is room,
  // emptied when the receiver takes the response.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (done && out_free) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done && out_free) begin
      rsp_data <= result;
    end
  end

endmodule

`default_nettype wire
